// ===== rtl/rbi_pkg.sv =====
package rbi_pkg;

  // Table size and Newton step count
  localparam int NUM_BODIES      = 64;
  localparam int IDX_W           = $clog2(NUM_BODIES);
  localparam int NORM_ITERATIONS = 3;
  localparam int ITER_W          = (NORM_ITERATIONS > 1) ? $clog2(NORM_ITERATIONS) : 1;

  // Step size register, unsigned Q1.16
  localparam int               STEP_W     = 17;
  localparam logic [STEP_W-1:0] STEP_RESET = 17'd546;

  typedef logic signed [31:0] word_t;
  typedef word_t [2:0] vec3_t;
  typedef word_t [3:0] quat_t;   // [0] x, [1] y, [2] z, [3] w

  // Shifted product and sums of a few of them
  typedef logic signed [47:0] prod_t;
  typedef logic signed [49:0] acc_t;

  typedef struct packed {
    vec3_t pos;
    quat_t rot;
    vec3_t lin;
    vec3_t ang;
    word_t recip_mass;
    vec3_t recip_inertia;
  } body_t;

  typedef enum logic [1:0] {
    CMD_STEP = 2'd0,
    CMD_POSE = 2'd1,
    CMD_VEL  = 2'd2,
    CMD_MASS = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_EXEC,
    ST_WB
  } state_e;

  // Step sequencer phases: each one issues the multiplier lanes, then combines
  typedef enum logic [4:0] {
    PH_QA, PH_QB, PH_QC,
    PH_T0, PH_T1, PH_T2,
    PH_IB,
    PH_C0, PH_C1, PH_C2,
    PH_WA, PH_WB,
    PH_DW, PH_DX, PH_DY, PH_DZ,
    PH_NN, PH_NS
  } phase_e;

  localparam word_t ONE30      = 32'sh4000_0000;
  localparam acc_t  ACC_ONE30  = 50'sd1073741824;
  localparam acc_t  ACC_THREE30 = 50'sd3221225472;
  localparam acc_t  ACC_MAX    = 50'sd2147483647;
  localparam acc_t  ACC_MIN    = -50'sd2147483648;

  function automatic acc_t ax(input word_t w);
    return acc_t'($signed(w));
  endfunction

  function automatic logic ovf32(input acc_t v);
    return (v > ACC_MAX) || (v < ACC_MIN);
  endfunction

  function automatic word_t sat32(input acc_t v);
    word_t r;
    if (v > ACC_MAX) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < ACC_MIN) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  function automatic body_t body_reset();
    body_t b;
    b = '0;
    b.rot[3] = ONE30;
    return b;
  endfunction

endpackage

// ===== rtl/rbi_step_unit.sv =====
module rbi_step_unit import rbi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  body_t             body_i,
  input  vec3_t             force_i,
  input  vec3_t             torque_i,
  input  logic [STEP_W-1:0] h_i,
  output logic              busy_o,
  output logic              done_o,
  output body_t             body_o,
  output logic              clip_o
);

  // Sequencer
  logic              busy_q, half_q, done_q;
  phase_e            phase_q, phase_d;
  logic [ITER_W-1:0] iter_q;
  logic              last_iter;

  // Working set
  body_t       body_q;
  vec3_t       f_q, t_q;
  logic [STEP_W-1:0] h_q;
  acc_t        qp_q [8];
  word_t       r_q [9];
  word_t       acc_q [3];
  word_t       a_q [3];
  word_t       c_q [3];
  word_t       wh_q [3];
  quat_t       qn_q;
  word_t       fac_q;
  logic        clip_q;

  // Multiplier lanes
  logic signed [32:0] ma [4];
  logic signed [32:0] mb [4];
  logic               sh30 [4];
  logic signed [65:0] prod [4];
  logic signed [65:0] pr_sh [4];
  prod_t              p_q [4];
  acc_t               pa [4];

  // Combine terms
  acc_t rv [9];
  logic rv_ovf;
  acc_t s3, dneg, dmix, nsum, facv;
  logic signed [32:0] hx;

  function automatic logic signed [32:0] x33(input word_t w);
    return {w[31], w};
  endfunction

  assign hx        = $signed({16'b0, h_q});
  assign last_iter = (iter_q == ITER_W'(NORM_ITERATIONS - 1));

  // Phase order; Newton steps loop until the last iteration
  always_comb begin
    unique case (phase_q)
      PH_QA:   phase_d = PH_QB;
      PH_QB:   phase_d = PH_QC;
      PH_QC:   phase_d = PH_T0;
      PH_T0:   phase_d = PH_T1;
      PH_T1:   phase_d = PH_T2;
      PH_T2:   phase_d = PH_IB;
      PH_IB:   phase_d = PH_C0;
      PH_C0:   phase_d = PH_C1;
      PH_C1:   phase_d = PH_C2;
      PH_C2:   phase_d = PH_WA;
      PH_WA:   phase_d = PH_WB;
      PH_WB:   phase_d = PH_DW;
      PH_DW:   phase_d = PH_DX;
      PH_DX:   phase_d = PH_DY;
      PH_DY:   phase_d = PH_DZ;
      PH_DZ:   phase_d = PH_NN;
      PH_NN:   phase_d = PH_NS;
      PH_NS:   phase_d = PH_NN;
      default: phase_d = PH_QA;
    endcase
  end

  // Lane operands per phase
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      ma[i]   = '0;
      mb[i]   = '0;
      sh30[i] = 1'b1;
    end
    unique case (phase_q)
      PH_QA: begin
        ma[0] = x33(body_q.rot[0]); mb[0] = x33(body_q.rot[0]);
        ma[1] = x33(body_q.rot[1]); mb[1] = x33(body_q.rot[1]);
        ma[2] = x33(body_q.rot[2]); mb[2] = x33(body_q.rot[2]);
        ma[3] = x33(body_q.rot[0]); mb[3] = x33(body_q.rot[1]);
      end
      PH_QB: begin
        ma[0] = x33(body_q.rot[0]); mb[0] = x33(body_q.rot[2]);
        ma[1] = x33(body_q.rot[1]); mb[1] = x33(body_q.rot[2]);
        ma[2] = x33(body_q.rot[3]); mb[2] = x33(body_q.rot[0]);
        ma[3] = x33(body_q.rot[3]); mb[3] = x33(body_q.rot[1]);
      end
      PH_QC: begin
        ma[0] = x33(body_q.rot[3]); mb[0] = x33(body_q.rot[2]);
        for (int i = 1; i < 4; i++) begin
          ma[i]   = x33(f_q[i-1]);
          mb[i]   = x33(body_q.recip_mass);
          sh30[i] = 1'b0;
        end
      end
      PH_T0: begin
        ma[0] = x33(r_q[0]); mb[0] = x33(t_q[0]);
        ma[1] = x33(r_q[3]); mb[1] = x33(t_q[1]);
        ma[2] = x33(r_q[6]); mb[2] = x33(t_q[2]);
        ma[3] = x33(acc_q[0]); mb[3] = hx; sh30[3] = 1'b0;
      end
      PH_T1: begin
        ma[0] = x33(r_q[1]); mb[0] = x33(t_q[0]);
        ma[1] = x33(r_q[4]); mb[1] = x33(t_q[1]);
        ma[2] = x33(r_q[7]); mb[2] = x33(t_q[2]);
        ma[3] = x33(acc_q[1]); mb[3] = hx; sh30[3] = 1'b0;
      end
      PH_T2: begin
        ma[0] = x33(r_q[2]); mb[0] = x33(t_q[0]);
        ma[1] = x33(r_q[5]); mb[1] = x33(t_q[1]);
        ma[2] = x33(r_q[8]); mb[2] = x33(t_q[2]);
        ma[3] = x33(acc_q[2]); mb[3] = hx; sh30[3] = 1'b0;
      end
      PH_IB: begin
        for (int i = 0; i < 3; i++) begin
          ma[i]   = x33(body_q.recip_inertia[i]);
          mb[i]   = x33(a_q[i]);
          sh30[i] = 1'b0;
        end
        ma[3] = x33(body_q.lin[0]); mb[3] = hx; sh30[3] = 1'b0;
      end
      PH_C0: begin
        ma[0] = x33(r_q[0]); mb[0] = x33(a_q[0]);
        ma[1] = x33(r_q[1]); mb[1] = x33(a_q[1]);
        ma[2] = x33(r_q[2]); mb[2] = x33(a_q[2]);
        ma[3] = x33(body_q.lin[1]); mb[3] = hx; sh30[3] = 1'b0;
      end
      PH_C1: begin
        ma[0] = x33(r_q[3]); mb[0] = x33(a_q[0]);
        ma[1] = x33(r_q[4]); mb[1] = x33(a_q[1]);
        ma[2] = x33(r_q[5]); mb[2] = x33(a_q[2]);
        ma[3] = x33(body_q.lin[2]); mb[3] = hx; sh30[3] = 1'b0;
      end
      PH_C2: begin
        ma[0] = x33(r_q[6]); mb[0] = x33(a_q[0]);
        ma[1] = x33(r_q[7]); mb[1] = x33(a_q[1]);
        ma[2] = x33(r_q[8]); mb[2] = x33(a_q[2]);
        ma[3] = x33(c_q[0]); mb[3] = hx; sh30[3] = 1'b0;
      end
      PH_WA: begin
        ma[0] = x33(c_q[1]);        mb[0] = hx; sh30[0] = 1'b0;
        ma[1] = x33(c_q[2]);        mb[1] = hx; sh30[1] = 1'b0;
        ma[2] = x33(body_q.ang[0]); mb[2] = hx; sh30[2] = 1'b0;
      end
      PH_WB: begin
        ma[0] = x33(body_q.ang[1]); mb[0] = hx; sh30[0] = 1'b0;
        ma[1] = x33(body_q.ang[2]); mb[1] = hx; sh30[1] = 1'b0;
      end
      PH_DW: begin
        ma[0] = x33(wh_q[0]); mb[0] = x33(body_q.rot[0]); sh30[0] = 1'b0;
        ma[1] = x33(wh_q[1]); mb[1] = x33(body_q.rot[1]); sh30[1] = 1'b0;
        ma[2] = x33(wh_q[2]); mb[2] = x33(body_q.rot[2]); sh30[2] = 1'b0;
      end
      PH_DX: begin
        ma[0] = x33(wh_q[0]); mb[0] = x33(body_q.rot[3]); sh30[0] = 1'b0;
        ma[1] = x33(wh_q[1]); mb[1] = x33(body_q.rot[2]); sh30[1] = 1'b0;
        ma[2] = x33(wh_q[2]); mb[2] = x33(body_q.rot[1]); sh30[2] = 1'b0;
      end
      PH_DY: begin
        ma[0] = x33(wh_q[1]); mb[0] = x33(body_q.rot[3]); sh30[0] = 1'b0;
        ma[1] = x33(wh_q[2]); mb[1] = x33(body_q.rot[0]); sh30[1] = 1'b0;
        ma[2] = x33(wh_q[0]); mb[2] = x33(body_q.rot[2]); sh30[2] = 1'b0;
      end
      PH_DZ: begin
        ma[0] = x33(wh_q[2]); mb[0] = x33(body_q.rot[3]); sh30[0] = 1'b0;
        ma[1] = x33(wh_q[0]); mb[1] = x33(body_q.rot[1]); sh30[1] = 1'b0;
        ma[2] = x33(wh_q[1]); mb[2] = x33(body_q.rot[0]); sh30[2] = 1'b0;
      end
      PH_NN: begin
        for (int i = 0; i < 4; i++) begin
          ma[i] = x33(qn_q[i]);
          mb[i] = x33(qn_q[i]);
        end
      end
      PH_NS: begin
        for (int i = 0; i < 4; i++) begin
          ma[i] = x33(qn_q[i]);
          mb[i] = x33(fac_q);
        end
      end
      default: begin
      end
    endcase
  end

  // Exact products, floor shift
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      prod[i]  = ma[i] * mb[i];
      pr_sh[i] = sh30[i] ? (prod[i] >>> 30) : (prod[i] >>> 16);
      pa[i]    = acc_t'(p_q[i]);
    end
  end

  // Rotation matrix from the quaternion products; wz arrives on lane 0
  always_comb begin
    rv[0] = ACC_ONE30 - ((qp_q[1] + qp_q[2]) <<< 1);
    rv[1] = (qp_q[3] - pa[0]) <<< 1;
    rv[2] = (qp_q[4] + qp_q[7]) <<< 1;
    rv[3] = (qp_q[3] + pa[0]) <<< 1;
    rv[4] = ACC_ONE30 - ((qp_q[0] + qp_q[2]) <<< 1);
    rv[5] = (qp_q[5] - qp_q[6]) <<< 1;
    rv[6] = (qp_q[4] - qp_q[7]) <<< 1;
    rv[7] = (qp_q[5] + qp_q[6]) <<< 1;
    rv[8] = ACC_ONE30 - ((qp_q[0] + qp_q[1]) <<< 1);
    rv_ovf = 1'b0;
    for (int i = 0; i < 9; i++) begin
      rv_ovf = rv_ovf | ovf32(rv[i]);
    end
  end

  // Lane sums shared by several phases
  always_comb begin
    s3   = pa[0] + pa[1] + pa[2];
    dneg = (-s3) >>> 1;
    dmix = (pa[0] + pa[1] - pa[2]) >>> 1;
    nsum = s3 + pa[3];
    facv = (ACC_THREE30 - nsum) >>> 1;
  end

  // Sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      half_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= PH_QA;
      iter_q  <= '0;
    end else if (start_i) begin
      busy_q  <= 1'b1;
      half_q  <= 1'b0;
      done_q  <= 1'b0;
      phase_q <= PH_QA;
      iter_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (busy_q) begin
        half_q <= ~half_q;
        if (half_q) begin
          phase_q <= phase_d;
          if (phase_q == PH_NS) begin
            if (last_iter) begin
              busy_q <= 1'b0;
              done_q <= 1'b1;
            end else begin
              iter_q <= iter_q + 1'b1;
            end
          end
        end
      end
    end
  end

  // Datapath: issue half registers lanes, combine half updates the working set
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      body_q <= body_i;
      f_q    <= force_i;
      t_q    <= torque_i;
      h_q    <= h_i;
      clip_q <= 1'b0;
    end else if (busy_q && !half_q) begin
      for (int i = 0; i < 4; i++) begin
        p_q[i] <= pr_sh[i][47:0];
      end
    end else if (busy_q) begin
      case (phase_q)
        PH_QA: begin
          for (int i = 0; i < 4; i++) qp_q[i] <= pa[i];
        end
        PH_QB: begin
          for (int i = 0; i < 4; i++) qp_q[i+4] <= pa[i];
        end
        PH_QC: begin
          for (int i = 0; i < 9; i++) r_q[i] <= sat32(rv[i]);
          for (int i = 0; i < 3; i++) acc_q[i] <= sat32(pa[i+1]);
          clip_q <= clip_q | rv_ovf | ovf32(pa[1]) | ovf32(pa[2]) | ovf32(pa[3]);
        end
        PH_T0: begin
          a_q[0]        <= sat32(s3);
          body_q.lin[0] <= sat32(ax(body_q.lin[0]) + pa[3]);
          clip_q <= clip_q | ovf32(s3) | ovf32(ax(body_q.lin[0]) + pa[3]);
        end
        PH_T1: begin
          a_q[1]        <= sat32(s3);
          body_q.lin[1] <= sat32(ax(body_q.lin[1]) + pa[3]);
          clip_q <= clip_q | ovf32(s3) | ovf32(ax(body_q.lin[1]) + pa[3]);
        end
        PH_T2: begin
          a_q[2]        <= sat32(s3);
          body_q.lin[2] <= sat32(ax(body_q.lin[2]) + pa[3]);
          clip_q <= clip_q | ovf32(s3) | ovf32(ax(body_q.lin[2]) + pa[3]);
        end
        PH_IB: begin
          for (int i = 0; i < 3; i++) a_q[i] <= sat32(pa[i]);
          body_q.pos[0] <= sat32(ax(body_q.pos[0]) + pa[3]);
          clip_q <= clip_q | ovf32(pa[0]) | ovf32(pa[1]) | ovf32(pa[2])
                  | ovf32(ax(body_q.pos[0]) + pa[3]);
        end
        PH_C0: begin
          c_q[0]        <= sat32(s3);
          body_q.pos[1] <= sat32(ax(body_q.pos[1]) + pa[3]);
          clip_q <= clip_q | ovf32(s3) | ovf32(ax(body_q.pos[1]) + pa[3]);
        end
        PH_C1: begin
          c_q[1]        <= sat32(s3);
          body_q.pos[2] <= sat32(ax(body_q.pos[2]) + pa[3]);
          clip_q <= clip_q | ovf32(s3) | ovf32(ax(body_q.pos[2]) + pa[3]);
        end
        PH_C2: begin
          c_q[2]        <= sat32(s3);
          body_q.ang[0] <= sat32(ax(body_q.ang[0]) + pa[3]);
          clip_q <= clip_q | ovf32(s3) | ovf32(ax(body_q.ang[0]) + pa[3]);
        end
        PH_WA: begin
          body_q.ang[1] <= sat32(ax(body_q.ang[1]) + pa[0]);
          body_q.ang[2] <= sat32(ax(body_q.ang[2]) + pa[1]);
          wh_q[0]       <= sat32(pa[2]);
          clip_q <= clip_q | ovf32(ax(body_q.ang[1]) + pa[0])
                  | ovf32(ax(body_q.ang[2]) + pa[1]) | ovf32(pa[2]);
        end
        PH_WB: begin
          wh_q[1] <= sat32(pa[0]);
          wh_q[2] <= sat32(pa[1]);
          clip_q  <= clip_q | ovf32(pa[0]) | ovf32(pa[1]);
        end
        PH_DW: begin
          qn_q[3] <= sat32(ax(body_q.rot[3]) + dneg);
          clip_q  <= clip_q | ovf32(ax(body_q.rot[3]) + dneg);
        end
        PH_DX: begin
          qn_q[0] <= sat32(ax(body_q.rot[0]) + dmix);
          clip_q  <= clip_q | ovf32(ax(body_q.rot[0]) + dmix);
        end
        PH_DY: begin
          qn_q[1] <= sat32(ax(body_q.rot[1]) + dmix);
          clip_q  <= clip_q | ovf32(ax(body_q.rot[1]) + dmix);
        end
        PH_DZ: begin
          qn_q[2] <= sat32(ax(body_q.rot[2]) + dmix);
          clip_q  <= clip_q | ovf32(ax(body_q.rot[2]) + dmix);
        end
        PH_NN: begin
          fac_q  <= sat32(facv);
          clip_q <= clip_q | ovf32(facv);
        end
        PH_NS: begin
          for (int i = 0; i < 4; i++) qn_q[i] <= sat32(pa[i]);
          clip_q <= clip_q | ovf32(pa[0]) | ovf32(pa[1]) | ovf32(pa[2]) | ovf32(pa[3]);
        end
        default: begin
        end
      endcase
    end
  end

  // Updated body, renormalized quaternion in place of the old one
  always_comb begin
    body_o     = body_q;
    body_o.rot = qn_q;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign clip_o = clip_q;

endmodule

// ===== rtl/rigid_body_integrator.sv =====
// Flow: a load command or a step on a static body passes through the read and write-back
// states, and its result word is registered on write back; a step on a moving body also
// waits in the exec state for the four-lane multiplier unit that walks the step phases.
// One word at a time: a new word is taken only once the last one has been written back.
// Reset: step size returns to 1/120 s and all body entries read as reset (valid bits
// cleared at once, no clearing pass).
module rigid_body_integrator import rbi_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [STEP_W-1:0] cfg_data_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        command_i,
  input  logic [IDX_W-1:0]  body_index_i,
  input  logic signed [31:0] vec_a_x_i,
  input  logic signed [31:0] vec_a_y_i,
  input  logic signed [31:0] vec_a_z_i,
  input  logic signed [31:0] vec_b_x_i,
  input  logic signed [31:0] vec_b_y_i,
  input  logic signed [31:0] vec_b_z_i,
  input  logic signed [31:0] scalar_w_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [IDX_W-1:0]  out_index_o,
  output logic signed [31:0] pos_x_o,
  output logic signed [31:0] pos_y_o,
  output logic signed [31:0] pos_z_o,
  output logic signed [31:0] rot_x_o,
  output logic signed [31:0] rot_y_o,
  output logic signed [31:0] rot_z_o,
  output logic signed [31:0] rot_w_o,
  output logic              is_static_o,
  output logic              saturated_o
);

  state_e state_q, state_d;

  logic [STEP_W-1:0] step_q;
  logic              accept, out_free, step_go;
  logic              rd_en, wr_en, start;

  cmd_e              cmd_q;
  logic [IDX_W-1:0]  idx_q;
  vec3_t             va_q, vb_q;
  word_t             sw_q;

  body_t             body_mem [NUM_BODIES];
  logic [NUM_BODIES-1:0] valid_q;
  body_t             rd_q, word_rd, word_mod, body_q;
  logic              static_q, sat_q;

  logic              step_busy, step_done, step_clip;
  body_t             step_body;

  logic              out_valid_q, out_static_q, out_sat_q;
  logic [IDX_W-1:0]  out_index_q;
  vec3_t             out_pos_q;
  quat_t             out_rot_q;

  assign cfg_ready_o = 1'b1;
  assign accept      = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;

  // Step size register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= STEP_RESET;
    end else if (cfg_valid_i) begin
      step_q <= cfg_data_i;
    end
  end

  // Entry read back, reset value for entries never written, command fields merged in
  always_comb begin
    word_rd  = valid_q[idx_q] ? rd_q : body_reset();
    word_mod = word_rd;
    case (cmd_q)
      CMD_POSE: begin
        word_mod.pos    = va_q;
        word_mod.rot[0] = vb_q[0];
        word_mod.rot[1] = vb_q[1];
        word_mod.rot[2] = vb_q[2];
        word_mod.rot[3] = sw_q;
      end
      CMD_VEL: begin
        word_mod.lin = va_q;
        word_mod.ang = vb_q;
      end
      CMD_MASS: begin
        word_mod.recip_inertia = va_q;
        word_mod.recip_mass    = sw_q;
      end
      default: begin
      end
    endcase
  end

  assign step_go = (cmd_q == CMD_STEP) && (word_rd.recip_mass != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (accept) state_d = ST_READ;
      ST_READ: state_d = step_go ? ST_EXEC : ST_WB;
      ST_EXEC: if (step_done) state_d = ST_WB;
      ST_WB:   if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // FSM outputs
  always_comb begin
    in_ready_o = 1'b0;
    start      = 1'b0;
    wr_en      = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_READ: start      = step_go;
      ST_EXEC: begin
      end
      ST_WB:   wr_en      = out_free;
      default: begin
      end
    endcase
  end

  assign rd_en = accept;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Body memory, one read and one write port, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      body_mem[idx_q] <= body_q;
    end
    if (rd_en) begin
      rd_q <= body_mem[body_index_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en) begin
      valid_q[idx_q] <= 1'b1;
    end
  end

  // Input word and working body
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= cmd_e'(command_i);
      idx_q <= body_index_i;
      va_q  <= {vec_a_z_i, vec_a_y_i, vec_a_x_i};
      vb_q  <= {vec_b_z_i, vec_b_y_i, vec_b_x_i};
      sw_q  <= scalar_w_i;
    end
    if (state_q == ST_READ) begin
      body_q   <= word_mod;
      static_q <= (cmd_q == CMD_STEP) && !step_go;
      sat_q    <= 1'b0;
    end else if (state_q == ST_EXEC && step_done) begin
      body_q <= step_body;
      sat_q  <= step_clip;
    end
  end

  rbi_step_unit u_step (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .body_i   (word_rd),
    .force_i  (va_q),
    .torque_i (vb_q),
    .h_i      (step_q),
    .busy_o   (step_busy),
    .done_o   (step_done),
    .body_o   (step_body),
    .clip_o   (step_clip)
  );

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (wr_en) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      out_index_q  <= idx_q;
      out_pos_q    <= body_q.pos;
      out_rot_q    <= body_q.rot;
      out_static_q <= static_q;
      out_sat_q    <= sat_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_index_o = out_index_q;
  assign pos_x_o     = out_pos_q[0];
  assign pos_y_o     = out_pos_q[1];
  assign pos_z_o     = out_pos_q[2];
  assign rot_x_o     = out_rot_q[0];
  assign rot_y_o     = out_rot_q[1];
  assign rot_z_o     = out_rot_q[2];
  assign rot_w_o     = out_rot_q[3];
  assign is_static_o = out_static_q;
  assign saturated_o = out_sat_q;

`ifndef ASSERT_OFF
  a_done_to_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC && step_done) |=> (state_q == ST_WB))
    else $error("step finish did not lead to write back");

  a_unit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !step_busy)
    else $error("new word taken while step unit busy");

  a_static_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && is_static_o) |-> !saturated_o)
    else $error("static body reported saturation");

  a_out_from_wb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_WB))
    else $error("result appeared without write back");
`endif

endmodule
